@@ rtl/assert_macros.svh @@
// Assertion helpers, clocked on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/twtlc_pkg.sv @@
`timescale 1ns / 1ps

package twtlc_pkg;

  localparam int TICKS_PER_SECOND = 1000;
  localparam int BLINK_TICKS      = 250;
  localparam int IDLE_TICKS       = 5000;

  localparam int SEC_W   = 8;
  localparam int CFG_W   = 7;
  localparam int PTMR_W  = 18;
  localparam int BTMR_W  = 8;
  localparam int ITMR_W  = 13;

  typedef logic [SEC_W-1:0]       sec_t;
  typedef logic [2:0][SEC_W-1:0]  sec3_t;
  typedef logic [2:0]             phase_t;
  typedef logic [1:0]             lamp_t;
  typedef logic [2:0]             mode_t;
  typedef logic [1:0]             colour_t;

  localparam phase_t PH_INIT = 3'd0;
  localparam phase_t PH_RG   = 3'd1;
  localparam phase_t PH_RY   = 3'd2;
  localparam phase_t PH_GR   = 3'd3;
  localparam phase_t PH_YR   = 3'd4;
  localparam phase_t PH_MR   = 3'd5;
  localparam phase_t PH_MY   = 3'd6;
  localparam phase_t PH_MG   = 3'd7;

  localparam lamp_t LAMP_OFF    = 2'd0;
  localparam lamp_t LAMP_RED    = 2'd1;
  localparam lamp_t LAMP_YELLOW = 2'd2;
  localparam lamp_t LAMP_GREEN  = 2'd3;

  localparam mode_t MODE_AUTO       = 3'd1;
  localparam mode_t MODE_ADJ_RED    = 3'd2;
  localparam mode_t MODE_ADJ_YELLOW = 3'd3;
  localparam mode_t MODE_ADJ_GREEN  = 3'd4;

  localparam colour_t COL_RED    = 2'd0;
  localparam colour_t COL_YELLOW = 2'd1;
  localparam colour_t COL_GREEN  = 2'd2;

  function automatic lamp_t lamp_a_of(input phase_t ph);
    lamp_t l;
    unique case (ph)
      PH_RG:   l = LAMP_RED;
      PH_RY:   l = LAMP_RED;
      PH_GR:   l = LAMP_GREEN;
      PH_YR:   l = LAMP_YELLOW;
      default: l = LAMP_OFF;
    endcase
    return l;
  endfunction

  function automatic lamp_t lamp_b_of(input phase_t ph);
    lamp_t l;
    unique case (ph)
      PH_RG:   l = LAMP_GREEN;
      PH_RY:   l = LAMP_YELLOW;
      PH_GR:   l = LAMP_RED;
      PH_YR:   l = LAMP_RED;
      default: l = LAMP_OFF;
    endcase
    return l;
  endfunction

  function automatic phase_t auto_next(input phase_t ph);
    phase_t n;
    unique case (ph)
      PH_RG:   n = PH_RY;
      PH_RY:   n = PH_GR;
      PH_GR:   n = PH_YR;
      default: n = PH_RG;
    endcase
    return n;
  endfunction

  function automatic phase_t adj_from_auto(input phase_t ph);
    phase_t n;
    unique case (ph)
      PH_GR:   n = PH_MG;
      PH_YR:   n = PH_MY;
      default: n = PH_MR;
    endcase
    return n;
  endfunction

  function automatic phase_t adj_next(input colour_t k);
    phase_t n;
    unique case (k)
      COL_RED:    n = PH_MY;
      COL_YELLOW: n = PH_MG;
      default:    n = PH_MR;
    endcase
    return n;
  endfunction

  function automatic phase_t adj_exit(input colour_t k);
    phase_t n;
    unique case (k)
      COL_RED:    n = PH_RG;
      COL_YELLOW: n = PH_YR;
      default:    n = PH_GR;
    endcase
    return n;
  endfunction

  function automatic sec_t wrap_to(input colour_t k);
    sec_t v;
    unique case (k)
      COL_RED:    v = 8'd5;
      COL_YELLOW: v = 8'd3;
      default:    v = 8'd2;
    endcase
    return v;
  endfunction

  function automatic sec_t sec_pick(input sec3_t s, input colour_t k);
    sec_t v;
    unique case (k)
      COL_YELLOW: v = s[1];
      COL_GREEN:  v = s[2];
      default:    v = s[0];
    endcase
    return v;
  endfunction

  function automatic sec3_t sec_set(input sec3_t s, input colour_t k, input sec_t v);
    sec3_t o;
    o = s;
    unique case (k)
      COL_RED:    o[0] = v;
      COL_YELLOW: o[1] = v;
      COL_GREEN:  o[2] = v;
      default:    o = s;
    endcase
    return o;
  endfunction

  // yellow phases run on the yellow time, all others on the green time
  function automatic logic [PTMR_W-1:0] timer_load(input phase_t ph, input sec3_t d);
    sec_t sel;
    sel = (ph == PH_RY || ph == PH_YR) ? d[1] : d[2];
    return PTMR_W'({{(PTMR_W-SEC_W){1'b0}}, sel} * PTMR_W'(TICKS_PER_SECOND));
  endfunction

  function automatic sec_t sat8(input logic signed [9:0] v);
    sec_t o;
    if (v < 0) begin
      o = '0;
    end else if (v > 10'sd255) begin
      o = 8'd255;
    end else begin
      o = v[7:0];
    end
    return o;
  endfunction

  function automatic sec3_t rebalance(input colour_t k, input sec3_t d, input sec_t e);
    logic signed [9:0] r;
    logic signed [9:0] y;
    logic signed [9:0] g;
    logic signed [9:0] t;
    logic signed [9:0] t2;
    sec3_t o;
    r = signed'({2'b00, d[0]});
    y = signed'({2'b00, d[1]});
    g = signed'({2'b00, d[2]});
    unique case (k)
      COL_RED: begin
        r = signed'({2'b00, e});
        t = r - y;
        if (t > g) begin
          g = t;
        end else if (t < g) begin
          t2 = r - g;
          if (t2 > y) begin
            y = t2;
          end else begin
            r = g + y;
          end
        end
      end
      COL_YELLOW: begin
        y = signed'({2'b00, e});
        t = r - y;
        if (t > g) begin
          g = t;
        end else if (t < g) begin
          r = y + g;
        end
      end
      COL_GREEN: begin
        g = signed'({2'b00, e});
        t = r - g;
        if (t > y) begin
          y = t;
        end else if (t < y) begin
          r = y + g;
        end
      end
      default: begin
        r = r;
      end
    endcase
    o[0] = sat8(r);
    o[1] = sat8(y);
    o[2] = sat8(g);
    return o;
  endfunction

endpackage

@@ rtl/two_way_traffic_light_controller.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake         | beat
// in      | input     | in_valid/in_stall   | three button presses, one tick
// out     | output    | out_valid/out_stall | lamps A and B, mode, edit value
// cfg     | input     | cfg_we (no wait)    | initial red/yellow/green seconds
//
// One tick per clock unless out_stall holds it: an input register feeds the
// tick logic, whose result is registered at the output with the state update.
// Reset is synchronous; the first beat after reset loads the initial times.
// A stalled output holds its beat; the input register still takes one more.

module two_way_traffic_light_controller (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_mode_press,
  input  logic                      in_step_press,
  input  logic                      in_confirm_press,
  output logic                      out_valid,
  input  logic                      out_stall,
  output twtlc_pkg::lamp_t          out_road_a_light,
  output twtlc_pkg::lamp_t          out_road_b_light,
  output twtlc_pkg::mode_t          out_mode_shown,
  output twtlc_pkg::sec_t           out_edit_value,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [twtlc_pkg::CFG_W-1:0] cfg_wdata
);
  import twtlc_pkg::*;

  localparam logic [1:0] REG_INIT_RED    = 2'd0;
  localparam logic [1:0] REG_INIT_YELLOW = 2'd1;
  localparam logic [1:0] REG_INIT_GREEN  = 2'd2;

  logic [CFG_W-1:0]  cfg_red_r, cfg_yel_r, cfg_grn_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_mode_r, s1_step_r, s1_conf_r;
  logic              in_take, s1_go;

  logic              out_valid_r, out_valid_nxt;
  lamp_t             out_a_r, out_b_r;
  mode_t             out_mode_r, out_mode_nxt;
  sec_t              out_edit_r, out_edit_nxt;

  phase_t            phase_r, phase_nxt;
  logic [PTMR_W-1:0] ptmr_r, ptmr_nxt;
  logic [BTMR_W-1:0] btmr_r, btmr_nxt;
  logic              blvl_r, blvl_nxt;
  logic [ITMR_W-1:0] itmr_r, itmr_nxt;
  sec3_t             dur_r, dur_nxt;
  sec3_t             edit_r, edit_nxt;
  lamp_t             lamp_a_r, lamp_a_nxt;
  lamp_t             lamp_b_r, lamp_b_nxt;

  colour_t           k, kn;
  sec3_t             cfg_secs, reb;
  sec_t              ek, ek_step;
  logic [SEC_W:0]    ek_inc;
  logic              pfire, bfire, ifire;

  assign in_take  = in_valid & ~in_stall;
  assign s1_go    = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & out_valid_r & out_stall;

  assign s1_valid_nxt  = in_take | (s1_valid_r & ~s1_go);
  assign out_valid_nxt = s1_go | (out_valid_r & out_stall);

  assign cfg_secs = {{(SEC_W-CFG_W){1'b0}}, cfg_grn_r,
                     {(SEC_W-CFG_W){1'b0}}, cfg_yel_r,
                     {(SEC_W-CFG_W){1'b0}}, cfg_red_r};

  assign k       = colour_t'(phase_r - PH_MR);
  assign ek      = sec_pick(edit_r, k);
  assign ek_inc  = {1'b0, ek} + 9'd1;
  assign ek_step = (ek_inc > 9'd99) ? wrap_to(k) : ek_inc[SEC_W-1:0];
  assign reb     = rebalance(k, dur_r, s1_step_r ? ek_step : ek);

  assign pfire = (ptmr_r <= PTMR_W'(1));
  assign bfire = (btmr_r <= BTMR_W'(1));
  assign ifire = (itmr_r <= ITMR_W'(1));

  always_comb begin
    phase_nxt  = phase_r;
    ptmr_nxt   = ptmr_r;
    btmr_nxt   = btmr_r;
    blvl_nxt   = blvl_r;
    itmr_nxt   = itmr_r;
    dur_nxt    = dur_r;
    edit_nxt   = edit_r;
    lamp_a_nxt = lamp_a_r;
    lamp_b_nxt = lamp_b_r;
    if (phase_r == PH_INIT) begin
      dur_nxt    = cfg_secs;
      edit_nxt   = cfg_secs;
      lamp_a_nxt = LAMP_OFF;
      lamp_b_nxt = LAMP_OFF;
      phase_nxt  = PH_RG;
      ptmr_nxt   = timer_load(PH_RG, cfg_secs);
    end else if (phase_r <= PH_YR) begin
      lamp_a_nxt = lamp_a_of(phase_r);
      lamp_b_nxt = lamp_b_of(phase_r);
      ptmr_nxt   = (ptmr_r == '0) ? '0 : ptmr_r - PTMR_W'(1);
      if (pfire) begin
        phase_nxt = auto_next(phase_r);
        ptmr_nxt  = timer_load(auto_next(phase_r), dur_r);
      end
      if (s1_mode_r) begin
        phase_nxt  = adj_from_auto(phase_r);
        lamp_a_nxt = LAMP_OFF;
        lamp_b_nxt = LAMP_OFF;
        blvl_nxt   = 1'b0;
        btmr_nxt   = BTMR_W'(BLINK_TICKS);
        itmr_nxt   = ITMR_W'(IDLE_TICKS);
      end
    end else begin
      btmr_nxt = (btmr_r == '0) ? '0 : btmr_r - BTMR_W'(1);
      itmr_nxt = (itmr_r == '0) ? '0 : itmr_r - ITMR_W'(1);
      if (bfire) begin
        blvl_nxt   = ~blvl_r;
        lamp_a_nxt = blvl_nxt ? lamp_t'(k + 2'd1) : LAMP_OFF;
        lamp_b_nxt = lamp_a_nxt;
        btmr_nxt   = BTMR_W'(BLINK_TICKS);
      end
      if (ifire) begin
        phase_nxt = adj_exit(k);
        ptmr_nxt  = timer_load(adj_exit(k), dur_r);
      end
      if (s1_mode_r) begin
        phase_nxt  = adj_next(k);
        lamp_a_nxt = LAMP_OFF;
        lamp_b_nxt = LAMP_OFF;
        blvl_nxt   = 1'b0;
        btmr_nxt   = BTMR_W'(BLINK_TICKS);
        itmr_nxt   = ITMR_W'(IDLE_TICKS);
      end else begin
        if (s1_step_r) begin
          edit_nxt = sec_set(edit_r, k, ek_step);
          itmr_nxt = ITMR_W'(IDLE_TICKS);
        end
        if (s1_conf_r) begin
          dur_nxt   = reb;
          edit_nxt  = reb;
          phase_nxt = adj_exit(k);
          ptmr_nxt  = timer_load(adj_exit(k), reb);
        end
      end
    end
  end

  assign kn = colour_t'(phase_nxt - PH_MR);

  always_comb begin
    if (phase_nxt >= PH_MR) begin
      out_mode_nxt = mode_t'(phase_nxt - PH_MR) + MODE_ADJ_RED;
      out_edit_nxt = sec_pick(edit_nxt, kn);
    end else begin
      out_mode_nxt = MODE_AUTO;
      out_edit_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_red_r   <= CFG_W'(5);
      cfg_yel_r   <= CFG_W'(2);
      cfg_grn_r   <= CFG_W'(3);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_INIT;
      ptmr_r      <= '0;
      btmr_r      <= '0;
      blvl_r      <= 1'b0;
      itmr_r      <= '0;
      dur_r       <= {8'd3, 8'd2, 8'd5};
      edit_r      <= {8'd3, 8'd2, 8'd5};
      lamp_a_r    <= LAMP_OFF;
      lamp_b_r    <= LAMP_OFF;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INIT_RED:    cfg_red_r <= cfg_wdata;
          REG_INIT_YELLOW: cfg_yel_r <= cfg_wdata;
          REG_INIT_GREEN:  cfg_grn_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        phase_r  <= phase_nxt;
        ptmr_r   <= ptmr_nxt;
        btmr_r   <= btmr_nxt;
        blvl_r   <= blvl_nxt;
        itmr_r   <= itmr_nxt;
        dur_r    <= dur_nxt;
        edit_r   <= edit_nxt;
        lamp_a_r <= lamp_a_nxt;
        lamp_b_r <= lamp_b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_mode_press;
      s1_step_r <= in_step_press;
      s1_conf_r <= in_confirm_press;
    end
    if (s1_go) begin
      out_a_r    <= lamp_a_nxt;
      out_b_r    <= lamp_b_nxt;
      out_mode_r <= out_mode_nxt;
      out_edit_r <= out_edit_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_road_a_light = out_a_r;
  assign out_road_b_light = out_b_r;
  assign out_mode_shown   = out_mode_r;
  assign out_edit_value   = out_edit_r;

endmodule

@@ rtl/twtlc_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twtlc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input twtlc_pkg::lamp_t            out_road_a_light,
  input twtlc_pkg::lamp_t            out_road_b_light,
  input twtlc_pkg::mode_t            out_mode_shown,
  input twtlc_pkg::sec_t             out_edit_value
);
  import twtlc_pkg::*;

  logic [14:0] out_bus;
  logic        out_held;
  logic        auto_shown;
  logic        adj_shown;
  logic        lamps_equal;

  assign out_bus     = {out_road_a_light, out_road_b_light, out_mode_shown, out_edit_value};
  assign out_held    = out_valid && out_stall;
  assign auto_shown  = out_valid && (out_mode_shown == MODE_AUTO);
  assign adj_shown   = out_valid && (out_mode_shown != MODE_AUTO);
  assign lamps_equal = (out_road_a_light == out_road_b_light);

  // stalled beat holds
  `ASSERT_RUN(a_out_hold, out_held |=> out_valid && $stable(out_bus), "stalled beat changed")
  // nothing comes out straight after reset
  `ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "out_valid set after reset")
  // an empty output stage never backs up the input
  `ASSERT_RUN(a_no_false_stall, !out_valid |-> !in_stall, "input stalled with output empty")
  // automatic mode shows no edit value
  `ASSERT_RUN(a_auto_edit_zero, auto_shown |-> out_edit_value == '0, "edit value in auto mode")
  // adjust modes blink both roads together
  `ASSERT_RUN(a_adj_lamps_same, adj_shown |-> lamps_equal, "roads differ in adjust mode")

endmodule

bind two_way_traffic_light_controller twtlc_checker u_twtlc_checker (.*);

@@ tb/sv/two_way_traffic_light_controller_tb.sv @@
`timescale 1ns / 1ps

import twtlc_pkg::*;

typedef struct packed {
  lamp_t road_a;
  lamp_t road_b;
  mode_t mode;
  sec_t  edit;
} lamp_view_t;

class lamp_scoreboard;
  logic [CFG_W-1:0]  initial_secs [3];
  phase_t            ph;
  logic [PTMR_W-1:0] phase_left;
  logic [BTMR_W-1:0] blink_left;
  logic [ITMR_W-1:0] idle_left;
  bit                blink_on;
  sec_t              durs [3];
  sec_t              edits [3];
  lamp_t             lamp_a;
  lamp_t             lamp_b;
  lamp_view_t        expected_lamps [$];
  int                beats_checked;
  int                errors;

  function new();
    initial_secs[COL_RED]    = 7'd5;
    initial_secs[COL_YELLOW] = 7'd2;
    initial_secs[COL_GREEN]  = 7'd3;
    ph         = PH_INIT;
    phase_left = '0;
    blink_left = '0;
    idle_left  = '0;
    blink_on   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      durs[i]  = sec_t'(initial_secs[i]);
      edits[i] = durs[i];
    end
    lamp_a        = LAMP_OFF;
    lamp_b        = LAMP_OFF;
    beats_checked = 0;
    errors        = 0;
  endfunction

  function void set_initial(logic [1:0] idx, logic [CFG_W-1:0] secs);
    if (idx < 2'd3) begin
      initial_secs[idx] = secs;
    end
  endfunction

  function int pending();
    return expected_lamps.size();
  endfunction

  // yellow phases run on the yellow time, the others on the green time
  function void start_auto(phase_t p);
    sec_t secs;
    secs       = (p == PH_RY || p == PH_YR) ? durs[COL_YELLOW] : durs[COL_GREEN];
    ph         = p;
    phase_left = PTMR_W'(int'(secs) * TICKS_PER_SECOND);
  endfunction

  function void start_adjust(phase_t p);
    ph         = p;
    lamp_a     = LAMP_OFF;
    lamp_b     = LAMP_OFF;
    blink_on   = 1'b0;
    blink_left = BTMR_W'(BLINK_TICKS);
    idle_left  = ITMR_W'(IDLE_TICKS);
  endfunction

  function phase_t resume_phase(colour_t k);
    case (k)
      COL_RED:    return PH_RG;
      COL_YELLOW: return PH_YR;
      default:    return PH_GR;
    endcase
  endfunction

  function sec_t clip_secs(int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > 255) begin
      return 8'd255;
    end
    return sec_t'(v);
  endfunction

  function void rebalance_durs(colour_t k);
    int r, y, g, t;
    r = durs[COL_RED];
    y = durs[COL_YELLOW];
    g = durs[COL_GREEN];
    case (k)
      COL_RED: begin
        r = edits[COL_RED];
        t = r - y;
        if (t > g) begin
          g = t;
        end else if (t < g) begin
          t = r - g;
          if (t > y) begin
            y = t;
          end else begin
            r = g + y;
          end
        end
      end
      COL_YELLOW: begin
        y = edits[COL_YELLOW];
        t = r - y;
        if (t > g) begin
          g = t;
        end else if (t < g) begin
          r = y + g;
        end
      end
      default: begin
        g = edits[COL_GREEN];
        t = r - g;
        if (t > y) begin
          y = t;
        end else if (t < y) begin
          r = y + g;
        end
      end
    endcase
    durs[COL_RED]    = clip_secs(r);
    durs[COL_YELLOW] = clip_secs(y);
    durs[COL_GREEN]  = clip_secs(g);
    edits = durs;
  endfunction

  function void note_tick(bit mode_p, bit step_p, bit conf_p);
    colour_t    k;
    bit         fired;
    bit         idle_fired;
    int         bumped;
    lamp_view_t v;
    if (ph == PH_INIT) begin
      for (int i = 0; i < 3; i++) begin
        durs[i]  = sec_t'(initial_secs[i]);
        edits[i] = durs[i];
      end
      lamp_a = LAMP_OFF;
      lamp_b = LAMP_OFF;
      start_auto(PH_RG);
    end else if (ph <= PH_YR) begin
      case (ph)
        PH_RG:   begin lamp_a = LAMP_RED;    lamp_b = LAMP_GREEN;  end
        PH_RY:   begin lamp_a = LAMP_RED;    lamp_b = LAMP_YELLOW; end
        PH_GR:   begin lamp_a = LAMP_GREEN;  lamp_b = LAMP_RED;    end
        default: begin lamp_a = LAMP_YELLOW; lamp_b = LAMP_RED;    end
      endcase
      fired = (phase_left <= 1);
      if (phase_left != 0) begin
        phase_left--;
      end
      k = (ph == PH_GR) ? COL_GREEN : (ph == PH_YR) ? COL_YELLOW : COL_RED;
      if (fired) begin
        case (ph)
          PH_RG:   start_auto(PH_RY);
          PH_RY:   start_auto(PH_GR);
          PH_GR:   start_auto(PH_YR);
          default: start_auto(PH_RG);
        endcase
      end
      if (mode_p) begin
        start_adjust(PH_MR + phase_t'(k));
      end
    end else begin
      k          = colour_t'(ph - PH_MR);
      fired      = (blink_left <= 1);
      idle_fired = (idle_left <= 1);
      if (blink_left != 0) begin
        blink_left--;
      end
      if (idle_left != 0) begin
        idle_left--;
      end
      if (fired) begin
        blink_on   = !blink_on;
        lamp_a     = blink_on ? lamp_t'(k + 1) : LAMP_OFF;
        lamp_b     = lamp_a;
        blink_left = BTMR_W'(BLINK_TICKS);
      end
      if (idle_fired) begin
        start_auto(resume_phase(k));
      end
      if (mode_p) begin
        case (k)
          COL_RED:    start_adjust(PH_MY);
          COL_YELLOW: start_adjust(PH_MG);
          default:    start_adjust(PH_MR);
        endcase
      end else begin
        if (step_p) begin
          bumped = int'(edits[k]) + 1;
          if (bumped > 99) begin
            case (k)
              COL_RED:    edits[k] = 8'd5;
              COL_YELLOW: edits[k] = 8'd3;
              default:    edits[k] = 8'd2;
            endcase
          end else begin
            edits[k] = sec_t'(bumped);
          end
          idle_left = ITMR_W'(IDLE_TICKS);
        end
        if (conf_p) begin
          rebalance_durs(k);
          start_auto(resume_phase(k));
        end
      end
    end
    v.road_a = lamp_a;
    v.road_b = lamp_b;
    if (ph >= PH_MR) begin
      v.mode = MODE_ADJ_RED + mode_t'(ph - PH_MR);
      v.edit = edits[colour_t'(ph - PH_MR)];
    end else begin
      v.mode = MODE_AUTO;
      v.edit = 8'd0;
    end
    expected_lamps.push_back(v);
  endfunction

  task report(string what);
    $display("ERROR beat %0d: %s", beats_checked, what);
    errors++;
  endtask

  task check_view(lamp_t a, lamp_t b, mode_t m, sec_t e);
    lamp_view_t want;
    beats_checked++;
    if (expected_lamps.size() == 0) begin
      report("result beat with no tick outstanding");
      return;
    end
    want = expected_lamps.pop_front();
    if (a !== want.road_a) begin
      report($sformatf("road A lamp %0d, want %0d", a, want.road_a));
    end
    if (b !== want.road_b) begin
      report($sformatf("road B lamp %0d, want %0d", b, want.road_b));
    end
    if (m !== want.mode) begin
      report($sformatf("mode %0d, want %0d", m, want.mode));
    end
    if (e !== want.edit) begin
      report($sformatf("edit value %0d, want %0d", e, want.edit));
    end
  endtask
endclass

module two_way_traffic_light_controller_tb;
  localparam logic [1:0] CFG_RED_SECONDS    = 2'd0;
  localparam logic [1:0] CFG_YELLOW_SECONDS = 2'd1;
  localparam logic [1:0] CFG_GREEN_SECONDS  = 2'd2;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TICKS_PER_RUN   = 350;

  logic             clk              = 1'b0;
  logic             rst_n            = 1'b0;
  logic             in_valid         = 1'b0;
  logic             in_stall;
  logic             in_mode_press    = 1'b0;
  logic             in_step_press    = 1'b0;
  logic             in_confirm_press = 1'b0;
  logic             out_valid;
  logic             out_stall        = 1'b0;
  lamp_t            out_road_a_light;
  lamp_t            out_road_b_light;
  mode_t            out_mode_shown;
  sec_t             out_edit_value;
  logic             cfg_we           = 1'b0;
  logic [1:0]       cfg_index        = '0;
  logic [CFG_W-1:0] cfg_wdata        = '0;

  lamp_scoreboard lights;
  int burst_left     = 0;
  bit steady_sender  = 1'b0;
  int hold_off_asked = 0;
  int hold_off_done  = 0;
  int hold_left      = 0;
  int stall_age      = 0;
  int stall_style    = 0;
  int ticks_offered  = 0;
  int quiet_cycles   = 0;

  wire in_beat  = in_valid && (in_stall === 1'b0);
  wire out_beat = (out_valid === 1'b1) && !out_stall;

  two_way_traffic_light_controller dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    stall_age++;
    if (stall_age % 200 == 0) begin
      stall_style = $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_off_asked != hold_off_done) begin
      hold_off_done = hold_off_asked;
      hold_left     = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= (stall_age % 7 < 3);
        default: out_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        lights.set_initial(cfg_index, cfg_wdata);
      end
      if (in_beat) begin
        lights.note_tick(in_mode_press, in_step_press, in_confirm_press);
      end
      if (out_beat) begin
        lights.check_view(out_road_a_light, out_road_b_light, out_mode_shown, out_edit_value);
      end
      if (in_beat || out_beat) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic bit coin();
    return bit'($urandom_range(0, 1));
  endfunction

  task automatic load_initial_times(input logic [CFG_W-1:0] red_s, yellow_s, green_s);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RED_SECONDS;
    cfg_wdata <= red_s;
    @(negedge clk);
    cfg_index <= CFG_YELLOW_SECONDS;
    cfg_wdata <= yellow_s;
    @(negedge clk);
    cfg_index <= CFG_GREEN_SECONDS;
    cfg_wdata <= green_s;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_tick(input bit m, s, c);
    @(negedge clk);
    in_valid         <= 1'b1;
    in_mode_press    <= m;
    in_step_press    <= s;
    in_confirm_press <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // payload wanders while valid is low
  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid         <= 1'b0;
      in_mode_press    <= coin();
      in_step_press    <= coin();
      in_confirm_press <= coin();
    end
  endtask

  task automatic offer(input bit m, s, c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_sender) begin
        pause_sender($urandom_range(0, 5));
      end
    end
    burst_left--;
    send_tick(m, s, c);
    ticks_offered++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lights.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_traffic(input int budget);
    int steps;
    ticks_offered = 0;
    while (ticks_offered < budget) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) offer(coin(), coin(), coin());
        1: repeat ($urandom_range(1, 40)) offer(1'b0, 1'b0, 1'b0);
        default: begin
          // adjust session: mode, optional extra mode presses, steps, then usually confirm
          offer(1'b1, 1'b0, 1'b0);
          repeat ($urandom_range(0, 2)) offer(1'b1, coin(), coin());
          steps = ($urandom_range(0, 15) == 0) ? $urandom_range(90, 110) : $urandom_range(0, 8);
          repeat (steps) begin
            if ($urandom_range(0, 5) == 0) begin
              offer(1'b0, 1'b0, 1'b0);
            end
            offer(1'b0, 1'b1, 1'b0);
          end
          if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(240, 300)) offer(1'b0, 1'b0, 1'b0);
          end
          case ($urandom_range(0, 4))
            0, 1, 2: offer(1'b0, coin(), 1'b1);
            3:       offer(1'b1, 1'b0, 1'b1);
            default: ;
          endcase
        end
      endcase
    end
  endtask

  initial begin
    int run;
    lights = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero times: every automatic phase lasts one tick
    load_initial_times(7'd0, 7'd0, 7'd0);
    offer(1'b1, 1'b1, 1'b1);
    offer(1'b0, 1'b1, 1'b1);
    offer(1'b1, 1'b0, 1'b0);
    offer(1'b0, 1'b0, 1'b1);
    offer(1'b0, 1'b0, 1'b0);
    offer(1'b0, 1'b0, 1'b0);
    offer(1'b1, 1'b0, 1'b0);
    offer(1'b1, 1'b1, 1'b1);
    offer(1'b1, 1'b0, 1'b0);
    offer(1'b0, 1'b0, 1'b1);
    offer(1'b1, 1'b0, 1'b0);
    offer(1'b0, 1'b1, 1'b0);
    offer(1'b1, 1'b0, 1'b0);
    offer(1'b0, 1'b0, 1'b1);
    offer(1'b0, 1'b0, 1'b0);
    offer(1'b1, 1'b0, 1'b0);
    offer(1'b0, 1'b1, 1'b1);
    offer(1'b1, 1'b0, 1'b0);

    for (run = 0; run < 4; run++) begin
      settle();
      case (run)
        0:       load_initial_times(7'd127, 7'd127, 7'd127);
        1:       load_initial_times(7'd1, 7'd1, 7'd1);
        2:       load_initial_times(7'd99, 7'd99, 7'd99);
        default: load_initial_times(7'd5, 7'd2, 7'd3);
      endcase
      steady_sender = (run == 2);
      if (run == 1) begin
        hold_off_asked++;
      end
      random_traffic(TICKS_PER_RUN);
    end

    settle();
    repeat (8) @(posedge clk);
    if (lights.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
